// ===== sv/sap_hdr_pkg.sv =====
// types and constants shared by the announcement header parser
// no dependencies; imported by every module of the block
package sap_hdr_pkg;

  // parse phase, one-hot; the terminator never sits in the phase register
  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_ORIGIN  = 5'b00010,
    PH_AUTH    = 5'b00100,
    PH_MIME    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    RG_HEADER  = 3'd0,
    RG_ORIGIN  = 3'd1,
    RG_AUTH    = 3'd2,
    RG_MIME    = 3'd3,
    RG_TERM    = 3'd4,
    RG_PAYLOAD = 3'd5
  } region_t;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_SHORT    = 2'd2,
    ST_NOMIME   = 2'd3
  } status_t;

  // header byte positions
  localparam logic [15:0] POS_FLAGS   = 16'd0;
  localparam logic [15:0] POS_AUTHLEN = 16'd1;
  localparam logic [15:0] POS_ID_LO   = 16'd2;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  // packet lengths, compared against the 17-bit byte count
  localparam logic [16:0] MIN_LEN = 17'd8;
  localparam logic [16:0] V4_END  = 17'd8;
  localparam logic [16:0] V6_END  = 17'd20;

  // flag byte layout
  localparam int FLG_VER_HI = 7;
  localparam int FLG_VER_LO = 5;
  localparam int FLG_V6     = 4;
  localparam int FLG_DEL    = 2;
  localparam int FLG_ENC    = 1;
  localparam int FLG_CMP    = 0;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    region_t     region;
    logic [2:0]  version;
    logic        ipv6_origin;
    logic        deletion;
    logic        encrypted;
    logic        compressed;
    logic [9:0]  auth_bytes;
    logic [15:0] message_id;
    status_t     status;
    logic        packet_done;
  } out_item_t;

endpackage

// ===== sv/sap_announcement_header_parser.sv =====
// top level of the announcement header parser: input and result registers
// around the decode core; depends on sap_hdr_pkg and sap_hdr_core
//
//   channel   ports                          carries
//   input     in_valid / in_ready / in_data  one packet byte and last-byte mark
//   result    out_valid / out_ready / out_data  tagged byte, header fields, status
//
// one byte per cycle while the result side keeps taking results; a byte goes
// through the input register, then the result register, from which it can
// transfer out
// the decode between the two registers is a single pass, state advances when
// a byte moves into the result register
// synchronous active-low reset clears both stages and the parse state
// a stalled result holds; the input register keeps taking bytes until it too
// is full
module sap_announcement_header_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sap_hdr_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sap_hdr_pkg::out_item_t out_data
);
  import sap_hdr_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      out_free;
  logic      step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  sap_hdr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/sap_hdr_core.sv =====
// parse state and per-byte decode of the announcement header
// depends on sap_hdr_pkg
module sap_hdr_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  sap_hdr_pkg::in_item_t item,
  output sap_hdr_pkg::out_item_t result
);
  import sap_hdr_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [9:0]  auth_len_r, auth_len_nxt;
  logic [15:0] id_r, id_nxt;
  logic [9:0]  auth_rem_r, auth_rem_nxt;
  logic        mime_seen_r, mime_seen_nxt;

  logic [16:0] pos_inc;
  region_t     region;
  status_t     status;
  logic [7:0]  b;

  assign b       = item.packet_byte;
  assign pos_inc = {1'b0, pos_r} + 17'd1;

  always_comb begin
    pos_nxt       = (pos_r == POS_MAX) ? pos_r : pos_inc[15:0];
    phase_nxt     = phase_r;
    flags_nxt     = flags_r;
    auth_len_nxt  = auth_len_r;
    id_nxt        = id_r;
    auth_rem_nxt  = auth_rem_r;
    mime_seen_nxt = mime_seen_r;
    region        = RG_PAYLOAD;
    unique case (phase_r)
      PH_HEADER: begin
        region = RG_HEADER;
        priority if (pos_r == POS_FLAGS) begin
          flags_nxt = b;
        end else if (pos_r == POS_AUTHLEN) begin
          auth_len_nxt = {b, 2'b00};
        end else if (pos_r == POS_ID_LO) begin
          id_nxt = {id_r[15:8], b};
        end else begin
          id_nxt    = {b, id_r[7:0]};
          phase_nxt = PH_ORIGIN;
        end
      end
      PH_ORIGIN: begin
        region = RG_ORIGIN;
        if (pos_inc >= (flags_r[FLG_V6] ? V6_END : V4_END)) begin
          if (auth_len_r != 10'd0) begin
            auth_rem_nxt = auth_len_r;
            phase_nxt    = PH_AUTH;
          end else begin
            phase_nxt = PH_MIME;
          end
        end
      end
      PH_AUTH: begin
        region       = RG_AUTH;
        auth_rem_nxt = auth_rem_r - 10'd1;
        if (auth_rem_nxt == 10'd0) begin
          phase_nxt = PH_MIME;
        end
      end
      PH_MIME: begin
        if (b == 8'd0) begin
          region    = RG_TERM;
          phase_nxt = PH_PAYLOAD;
        end else begin
          region        = RG_MIME;
          mime_seen_nxt = 1'b1;
        end
      end
      default: begin
        region    = RG_PAYLOAD;
        phase_nxt = PH_PAYLOAD;
      end
    endcase

    status = ST_PENDING;
    if (item.final_byte) begin
      priority if (pos_inc < MIN_LEN || phase_nxt == PH_HEADER ||
                   phase_nxt == PH_ORIGIN || phase_nxt == PH_AUTH) begin
        status = ST_SHORT;
      end else if (mime_seen_nxt) begin
        status = ST_ACCEPTED;
      end else begin
        status = ST_NOMIME;
      end
    end
  end

  // decoded fields show the state after this byte
  always_comb begin
    result.byte_out    = b;
    result.region      = region;
    result.version     = flags_nxt[FLG_VER_HI:FLG_VER_LO];
    result.ipv6_origin = flags_nxt[FLG_V6];
    result.deletion    = flags_nxt[FLG_DEL];
    result.encrypted   = flags_nxt[FLG_ENC];
    result.compressed  = flags_nxt[FLG_CMP];
    result.auth_bytes  = auth_len_nxt;
    result.message_id  = id_nxt;
    result.status      = status;
    result.packet_done = item.final_byte;
  end

  // the final byte returns the parser to its start state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.final_byte)) begin
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      flags_r     <= '0;
      auth_len_r  <= '0;
      id_r        <= '0;
      auth_rem_r  <= '0;
      mime_seen_r <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      auth_len_r  <= auth_len_nxt;
      id_r        <= id_nxt;
      auth_rem_r  <= auth_rem_nxt;
      mime_seen_r <= mime_seen_nxt;
    end
  end

endmodule

// ===== sv/sap_hdr_checker.sv =====
// port-level checks for the announcement header parser, bound to the top level
// depends on sap_hdr_pkg
module sap_hdr_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input sap_hdr_pkg::out_item_t out_data
);
  import sap_hdr_pkg::*;

  // set after a result transfer that closed a packet
  logic pkt_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      pkt_start_r <= out_data.packet_done;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.packet_done == (out_data.status != ST_PENDING)))
    else $error("status and packet end disagree");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pkt_start_r |->
      out_data.region == RG_HEADER && out_data.auth_bytes == 10'd0 &&
      out_data.message_id == 16'd0)
    else $error("first byte of a packet not parsed from a clean state");

  a_auth_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.auth_bytes[1:0] == 2'b00)
    else $error("auth length not a whole number of words");

  a_early_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_done && out_data.region == RG_HEADER |->
      out_data.status == ST_SHORT)
    else $error("packet ending in header not flagged short");

endmodule

bind sap_announcement_header_parser sap_hdr_checker u_sap_hdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/sap_hdr_tag_checker.sv =====
// result checker for the announcement header parser: predicts the tag and
// header fields of every accepted byte and compares them in order
// depends on sap_hdr_pkg
`timescale 1ns / 100ps

module sap_hdr_tag_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  sap_hdr_pkg::in_item_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  sap_hdr_pkg::out_item_t out_data,
  output int                     fail_count,
  output int                     open_results
);
  import sap_hdr_pkg::*;

  // parse state mirrored from the byte stream
  logic [15:0] byte_count;
  region_t     parse_region;
  logic [7:0]  flag_reg;
  logic [9:0]  auth_len_bytes;
  logic [15:0] msg_id;
  logic [9:0]  auth_left;
  logic        mime_seen;

  out_item_t   expected_tags[$];

  function automatic void clear_parse();
    byte_count     = '0;
    parse_region   = RG_HEADER;
    flag_reg       = '0;
    auth_len_bytes = '0;
    msg_id         = '0;
    auth_left      = '0;
    mime_seen      = 1'b0;
  endfunction

  function automatic out_item_t tag_next_byte(input in_item_t item);
    out_item_t   res;
    region_t     rgn;
    region_t     nxt;
    logic [16:0] count;
    logic [16:0] origin_end;
    nxt   = parse_region;
    rgn   = RG_PAYLOAD;
    count = {1'b0, byte_count} + 17'd1;
    case (parse_region)
      RG_HEADER: begin
        rgn = RG_HEADER;
        if (byte_count == POS_FLAGS) begin
          flag_reg = item.packet_byte;
        end else if (byte_count == POS_AUTHLEN) begin
          auth_len_bytes = {item.packet_byte, 2'b00};
        end else if (byte_count == POS_ID_LO) begin
          msg_id[7:0] = item.packet_byte;
        end else begin
          msg_id[15:8] = item.packet_byte;
          nxt = RG_ORIGIN;
        end
      end
      RG_ORIGIN: begin
        rgn = RG_ORIGIN;
        origin_end = flag_reg[FLG_V6] ? V6_END : V4_END;
        if (count >= origin_end) begin
          if (auth_len_bytes != '0) begin
            auth_left = auth_len_bytes;
            nxt = RG_AUTH;
          end else begin
            nxt = RG_MIME;
          end
        end
      end
      RG_AUTH: begin
        rgn = RG_AUTH;
        auth_left = auth_left - 10'd1;
        if (auth_left == '0) nxt = RG_MIME;
      end
      RG_MIME: begin
        if (item.packet_byte == 8'h00) begin
          rgn = RG_TERM;
          nxt = RG_PAYLOAD;
        end else begin
          rgn = RG_MIME;
          mime_seen = 1'b1;
        end
      end
      default: begin
        rgn = RG_PAYLOAD;
        nxt = RG_PAYLOAD;
      end
    endcase

    parse_region = nxt;
    if (byte_count != POS_MAX) byte_count = byte_count + 16'd1;

    res.byte_out    = item.packet_byte;
    res.region      = rgn;
    res.version     = flag_reg[FLG_VER_HI:FLG_VER_LO];
    res.ipv6_origin = flag_reg[FLG_V6];
    res.deletion    = flag_reg[FLG_DEL];
    res.encrypted   = flag_reg[FLG_ENC];
    res.compressed  = flag_reg[FLG_CMP];
    res.auth_bytes  = auth_len_bytes;
    res.message_id  = msg_id;
    res.packet_done = item.final_byte;
    res.status      = ST_PENDING;
    if (item.final_byte) begin
      // still inside header, origin or auth data means the packet was cut
      if (count < MIN_LEN || nxt == RG_HEADER || nxt == RG_ORIGIN || nxt == RG_AUTH)
        res.status = ST_SHORT;
      else if (mime_seen)
        res.status = ST_ACCEPTED;
      else
        res.status = ST_NOMIME;
      clear_parse();
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_parse();
      expected_tags.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) expected_tags.push_back(tag_next_byte(in_data));
      if (out_valid && out_ready) begin
        if (expected_tags.size() == 0) begin
          $error("result transfer with no byte outstanding, byte_out %0h",
                 out_data.byte_out);
          fail_count++;
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_out",    32'(want.byte_out),    32'(out_data.byte_out));
          check_field("region",      32'(want.region),      32'(out_data.region));
          check_field("version",     32'(want.version),     32'(out_data.version));
          check_field("ipv6_origin", 32'(want.ipv6_origin), 32'(out_data.ipv6_origin));
          check_field("deletion",    32'(want.deletion),    32'(out_data.deletion));
          check_field("encrypted",   32'(want.encrypted),   32'(out_data.encrypted));
          check_field("compressed",  32'(want.compressed),  32'(out_data.compressed));
          check_field("auth_bytes",  32'(want.auth_bytes),  32'(out_data.auth_bytes));
          check_field("message_id",  32'(want.message_id),  32'(out_data.message_id));
          check_field("status",      32'(want.status),      32'(out_data.status));
          check_field("packet_done", 32'(want.packet_done), 32'(out_data.packet_done));
        end
      end
    end
    open_results = expected_tags.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the announcement header parser: clock, reset, packet
// stimulus and result-side flow control; depends on sap_hdr_pkg,
// sap_announcement_header_parser and sap_hdr_tag_checker
`timescale 1ns / 100ps

module tb_top;
  import sap_hdr_pkg::*;

  localparam int RANDOM_BYTES = 1400;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_CYCLES  = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int        fail_count;
  int        open_results;
  int        bytes_sent;
  bit        rx_stalls;
  bit        hold_rx;
  bit        hold_done;
  logic [7:0] ann_bytes[$];

  sap_announcement_header_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sap_hdr_tag_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit gaps);
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{packet_byte: b, final_byte: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_announcement(input bit gaps);
    foreach (ann_bytes[i]) send_byte(ann_bytes[i], i == ann_bytes.size() - 1, gaps);
  endtask

  task automatic build_announcement(input logic [7:0] flags, input int auth_words,
                                    input int mime_len, input bit term,
                                    input int payload_len);
    int origin_len;
    ann_bytes.delete();
    ann_bytes.push_back(flags);
    ann_bytes.push_back(8'(auth_words));
    ann_bytes.push_back(8'($urandom_range(0, 255)));
    ann_bytes.push_back(8'($urandom_range(0, 255)));
    origin_len = flags[FLG_V6] ? 16 : 4;
    repeat (origin_len) ann_bytes.push_back(8'($urandom_range(0, 255)));
    repeat (4 * auth_words) ann_bytes.push_back(8'($urandom_range(0, 255)));
    repeat (mime_len) ann_bytes.push_back(8'($urandom_range(1, 255)));
    if (term) ann_bytes.push_back(8'h00);
    // payload carries zero bytes now and then
    repeat (payload_len)
      ann_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  pkt_count;
    int  pick;
    int  cut;
    int  words;
    bit  quiet;
    bit  tx_gaps;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    rx_stalls  = 1'b0;
    hold_rx    = 1'b0;
    bytes_sent = 0;
    pkt_count  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-byte packet, all flag bits set
    ann_bytes.delete();
    ann_bytes.push_back(8'hFF);
    send_announcement(1'b0);
    // empty mime type: terminator comes first
    build_announcement(8'h20, 0, 0, 1'b1, 0);
    send_announcement(1'b0);
    // packet stops exactly where the mime type would start
    build_announcement(8'h00, 0, 0, 1'b0, 0);
    send_announcement(1'b0);
    // mime type with no terminator
    build_announcement(8'hCF, 0, 1, 1'b0, 0);
    send_announcement(1'b0);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      quiet     = bytes_sent >= RANDOM_BYTES - QUIET_TAIL;
      tx_gaps   = !quiet && ($urandom_range(0, 3) != 0);
      rx_stalls = !quiet && ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 9);
      if (pkt_count == 12)
        words = 255;
      else if ($urandom_range(0, 7) == 0)
        words = $urandom_range(4, 15);
      else
        words = $urandom_range(0, 3);
      if (pick < 9) begin
        build_announcement(8'($urandom_range(0, 255)), words,
                           ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8),
                           $urandom_range(0, 9) != 0, $urandom_range(0, 12));
        if (pick >= 7) begin
          cut = $urandom_range(1, ann_bytes.size());
          while (ann_bytes.size() > cut) void'(ann_bytes.pop_back());
        end
      end else begin
        ann_bytes.delete();
        repeat ($urandom_range(1, 24)) ann_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (pkt_count == 6) begin
        // hold the result side while bytes keep coming, so the input stalls
        @(negedge clk);
        hold_rx = 1'b1;
        send_announcement(1'b0);
      end else begin
        send_announcement(tx_gaps);
      end
      pkt_count++;
    end

    rx_stalls = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sap_hdr_pkg.sv
sv/sap_hdr_core.sv
sv/sap_announcement_header_parser.sv
sv/sap_hdr_checker.sv
verif/sap_hdr_tag_checker.sv
verif/tb_top.sv
